// ===== hdl/dmc_pkg.sv =====
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int unsigned MAX_SIDE = 64;
  localparam int unsigned COORD_W = $clog2(MAX_SIDE);
  localparam int unsigned CELL_W = 2 * COORD_W;
  localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
  localparam int unsigned DEPTH_W = CELL_W + 1;
  localparam int unsigned SIDE_W = COORD_W + 1;
  localparam int unsigned RAND_W = 15;

  localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(40);

  typedef enum logic [1:0] {
    ACT_CARVE     = 2'd0,
    ACT_BACKTRACK = 2'd1,
    ACT_FINISHED  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4
  } state_e;

  function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = 5'(v[RAND_W-1]);
    for (int i = 0; i < (RAND_W - 1) / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 4'(s[4:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

endpackage

// ===== hdl/dfs_maze_carver.sv =====
`timescale 1ns / 1ps
// A request accepted in ST_IDLE runs through ST_RD1 to ST_RD4, where the result
// is registered once the output is free; a new request waits for ST_IDLE. The
// four neighbor lookups share the single read port of the visited-cell memory.
// Reset: an asynchronous clear is followed by a pass that clears the
// visited-cell memory, during which input requests are stalled.
module dfs_maze_carver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dmc_pkg::SIDE_W-1:0]        cfg_grid_side_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dmc_pkg::RAND_W-1:0]        random_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        action_o,
  output logic [dmc_pkg::COORD_W-1:0]       from_x_o,
  output logic [dmc_pkg::COORD_W-1:0]       from_y_o,
  output logic [dmc_pkg::COORD_W-1:0]       to_x_o,
  output logic [dmc_pkg::COORD_W-1:0]       to_y_o,
  output logic [1:0]                        wall_side_o,
  output logic [dmc_pkg::DEPTH_W-1:0]       depth_o
);

  localparam int unsigned CW = dmc_pkg::COORD_W;
  localparam int unsigned LW = dmc_pkg::CELL_W;
  localparam int unsigned DW = dmc_pkg::DEPTH_W;
  localparam int unsigned SW = dmc_pkg::SIDE_W;

  dmc_pkg::state_e state_q, state_d;

  logic [SW-1:0] side_q;
  logic [SW-1:0] side_eff;
  logic          clr_busy_q;
  logic [LW-1:0] clr_addr_q;
  logic [DW-1:0] cnt_q;
  logic [CW-1:0] cx_q, cy_q;
  logic [dmc_pkg::RAND_W-1:0] rv_q;
  logic [1:0]    rv_mod3_q;
  logic [2:0]    open_q;

  logic          vis_mem [dmc_pkg::CELLS];
  logic          vis_rd_q;
  logic [LW-1:0] stk_mem [dmc_pkg::CELLS];
  logic [LW-1:0] stk_rd_q;

  logic          out_valid_q;
  logic [1:0]    action_q;
  logic [CW-1:0] from_x_q, from_y_q, to_x_q, to_y_q;
  logic [1:0]    wall_q;
  logic [DW-1:0] depth_q;

  logic          in_accept;
  logic          out_free;
  logic          commit;
  logic          vis_re;
  logic [1:0]    rd_dir;
  logic [1:0]    chk_dir;
  logic          chk_open;
  logic [3:0]    open_all;
  logic [2:0]    n_open;
  logic [1:0]    k_sel;
  logic [1:0]    pick;
  logic          any_open;

  logic [CW-1:0] nb_x [4];
  logic [CW-1:0] nb_y [4];
  logic [3:0]    in_grid;
  logic [LW-1:0] nb_cell [4];
  logic [LW-1:0] pop_top;

  logic          vis_we;
  logic [LW-1:0] vis_wa;
  logic          vis_wd;
  logic          stk_we;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (side_q < dmc_pkg::SIDE_MIN) begin
      side_eff = dmc_pkg::SIDE_MIN;
    end else if (side_q > dmc_pkg::SIDE_MAX) begin
      side_eff = dmc_pkg::SIDE_MAX;
    end else begin
      side_eff = side_q;
    end
  end

  always_comb begin
    nb_x[dmc_pkg::DIR_UP]    = cx_q;
    nb_y[dmc_pkg::DIR_UP]    = cy_q - CW'(1);
    nb_x[dmc_pkg::DIR_RIGHT] = cx_q + CW'(1);
    nb_y[dmc_pkg::DIR_RIGHT] = cy_q;
    nb_x[dmc_pkg::DIR_DOWN]  = cx_q;
    nb_y[dmc_pkg::DIR_DOWN]  = cy_q + CW'(1);
    nb_x[dmc_pkg::DIR_LEFT]  = cx_q - CW'(1);
    nb_y[dmc_pkg::DIR_LEFT]  = cy_q;
    in_grid[dmc_pkg::DIR_UP] = (cy_q != '0) && ({1'b0, cx_q} < side_eff)
                               && ({1'b0, cy_q} - SW'(1) < side_eff);
    in_grid[dmc_pkg::DIR_RIGHT] = ({1'b0, cx_q} + SW'(1) < side_eff)
                                  && ({1'b0, cy_q} < side_eff);
    in_grid[dmc_pkg::DIR_DOWN] = ({1'b0, cx_q} < side_eff)
                                 && ({1'b0, cy_q} + SW'(1) < side_eff);
    in_grid[dmc_pkg::DIR_LEFT] = (cx_q != '0) && ({1'b0, cx_q} - SW'(1) < side_eff)
                                 && ({1'b0, cy_q} < side_eff);
    for (int d = 0; d < 4; d++) begin
      nb_cell[d] = {nb_x[d], nb_y[d]};
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmc_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = dmc_pkg::ST_RD1;
        end
      end
      dmc_pkg::ST_RD1: state_d = dmc_pkg::ST_RD2;
      dmc_pkg::ST_RD2: state_d = dmc_pkg::ST_RD3;
      dmc_pkg::ST_RD3: state_d = dmc_pkg::ST_RD4;
      dmc_pkg::ST_RD4: begin
        if (out_free) begin
          state_d = dmc_pkg::ST_IDLE;
        end
      end
      default: state_d = dmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    vis_re     = 1'b0;
    rd_dir     = dmc_pkg::DIR_UP;
    chk_dir    = dmc_pkg::DIR_UP;
    commit     = 1'b0;
    case (state_q)
      dmc_pkg::ST_IDLE: begin
        in_stall_o = clr_busy_q;
        vis_re     = in_accept;
        rd_dir     = dmc_pkg::DIR_UP;
      end
      dmc_pkg::ST_RD1: begin
        vis_re  = 1'b1;
        rd_dir  = dmc_pkg::DIR_RIGHT;
        chk_dir = dmc_pkg::DIR_UP;
      end
      dmc_pkg::ST_RD2: begin
        vis_re  = 1'b1;
        rd_dir  = dmc_pkg::DIR_DOWN;
        chk_dir = dmc_pkg::DIR_RIGHT;
      end
      dmc_pkg::ST_RD3: begin
        vis_re  = 1'b1;
        rd_dir  = dmc_pkg::DIR_LEFT;
        chk_dir = dmc_pkg::DIR_DOWN;
      end
      dmc_pkg::ST_RD4: begin
        chk_dir = dmc_pkg::DIR_LEFT;
        commit  = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Cell zero is visited from reset on, so its stored bit is never consulted.
  assign chk_open = in_grid[chk_dir] && !vis_rd_q && (nb_cell[chk_dir] != '0);
  assign open_all = {chk_open, open_q};
  assign n_open   = 3'($countones(open_all));
  assign any_open = (n_open != 3'd0);

  always_comb begin
    case (n_open)
      3'd2:    k_sel = {1'b0, rv_q[0]};
      3'd3:    k_sel = rv_mod3_q;
      3'd4:    k_sel = rv_q[1:0];
      default: k_sel = 2'd0;
    endcase
  end

  always_comb begin
    logic [1:0] seen;
    logic       found;
    seen  = 2'd0;
    found = 1'b0;
    pick  = dmc_pkg::DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (open_all[d] && !found) begin
        if (seen == k_sel) begin
          pick  = 2'(d);
          found = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign pop_top = (cnt_q == DW'(2)) ? '0 : stk_rd_q;

  always_comb begin
    vis_we = 1'b0;
    vis_wa = nb_cell[pick];
    vis_wd = 1'b1;
    if (clr_busy_q) begin
      vis_we = 1'b1;
      vis_wa = clr_addr_q;
      vis_wd = 1'b0;
    end else if (commit && any_open) begin
      vis_we = 1'b1;
    end
  end

  assign stk_we = commit && any_open && (cnt_q < DW'(dmc_pkg::CELLS));

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (vis_re) begin
      vis_rd_q <= vis_mem[nb_cell[rd_dir]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[cnt_q[LW-1:0]] <= nb_cell[pick];
    end
    if (in_accept) begin
      stk_rd_q <= stk_mem[cnt_q[LW-1:0] - LW'(2)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rv_q      <= random_value_i;
      rv_mod3_q <= dmc_pkg::mod3(random_value_i);
    end
    case (state_q)
      dmc_pkg::ST_RD1: open_q[0] <= chk_open;
      dmc_pkg::ST_RD2: open_q[1] <= chk_open;
      dmc_pkg::ST_RD3: open_q[2] <= chk_open;
      default: open_q <= open_q;
    endcase
    if (commit) begin
      from_x_q <= cx_q;
      from_y_q <= cy_q;
      if (any_open) begin
        action_q <= dmc_pkg::ACT_CARVE;
        to_x_q   <= nb_x[pick];
        to_y_q   <= nb_y[pick];
        wall_q   <= pick;
        depth_q  <= stk_we ? cnt_q + DW'(1) : cnt_q;
      end else if (cnt_q > DW'(1)) begin
        action_q <= dmc_pkg::ACT_BACKTRACK;
        to_x_q   <= pop_top[LW-1:CW];
        to_y_q   <= pop_top[CW-1:0];
        wall_q   <= dmc_pkg::DIR_UP;
        depth_q  <= cnt_q - DW'(1);
      end else begin
        action_q <= dmc_pkg::ACT_FINISHED;
        to_x_q   <= cx_q;
        to_y_q   <= cy_q;
        wall_q   <= dmc_pkg::DIR_UP;
        depth_q  <= cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmc_pkg::ST_IDLE;
      side_q      <= dmc_pkg::SIDE_RESET;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      cnt_q       <= DW'(1);
      cx_q        <= '0;
      cy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        side_q <= cfg_grid_side_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + LW'(1);
        if (clr_addr_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (any_open) begin
          cx_q <= nb_x[pick];
          cy_q <= nb_y[pick];
          if (stk_we) begin
            cnt_q <= cnt_q + DW'(1);
          end
        end else if (cnt_q > DW'(1)) begin
          cx_q  <= pop_top[LW-1:CW];
          cy_q  <= pop_top[CW-1:0];
          cnt_q <= cnt_q - DW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign from_x_o    = from_x_q;
  assign from_y_o    = from_y_q;
  assign to_x_o      = to_x_q;
  assign to_y_o      = to_y_q;
  assign wall_side_o = wall_q;
  assign depth_o     = depth_q;

endmodule
